/* rtl/online_centroid_clustering_macros.svh */
// Assertion macros used by the clustering port checker.
`ifndef ONLINE_CENTROID_CLUSTERING_MACROS_SVH
`define ONLINE_CENTROID_CLUSTERING_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define OCC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("occ check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define OCC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("occ check failed");

`endif

/* rtl/occ_pkg.sv */
// Package: constants, types and codes of the centroid clustering block.
package occ_pkg;

    localparam int MAX_CENTROIDS = 64;
    localparam int FRAC_BITS     = 8;
    localparam int COORD_BITS    = 10;

    localparam int IN_COORD_W  = 10;
    localparam int OUT_COORD_W = 10;
    localparam int RADIUS_W    = 8;
    localparam int COUNT_W     = 21;
    localparam int MEAN_W      = COORD_BITS + FRAC_BITS;
    localparam int STEP_W      = $clog2(MAX_CENTROIDS + 1);
    localparam int RAD_W       = RADIUS_W + 1 + FRAC_BITS;
    localparam int SQ_W        = 2 * RAD_W;
    localparam int D2_W        = (2 * MEAN_W + 1 > SQ_W) ? 2 * MEAN_W + 1 : SQ_W;
    localparam int NUM_W       = MEAN_W + COUNT_W + 1;
    localparam int DEN_W       = COUNT_W + 1;
    localparam int DIV_CNT_W   = $clog2(MEAN_W);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(15);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = COUNT_W'(1) << 20;

    typedef enum logic [0:0] {
        CMD_POINT = 1'b0,
        CMD_EOF   = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQR,
        ST_SQC,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_ROT,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        ROT_KEEP,
        ROT_INSERT,
        ROT_INSERT_SHIFT
    } t_rot;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_row;
        logic [MEAN_W-1:0]  mean_col;
        logic [COUNT_W-1:0] count;
        logic               active;
    } t_entry;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
        logic [COUNT_W-1:0]     count;
        logic                   found;
        logic                   ovf;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

endpackage

/* rtl/occ_point_if.sv */
// Interface: input channel carrying points and end-of-frame commands.
interface occ_point_if;
    import occ_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [IN_COORD_W-1:0] point_row;
    logic [IN_COORD_W-1:0] point_col;

    modport source (output valid, command, point_row, point_col, input ready);
    modport sink   (input valid, command, point_row, point_col, output ready);
endinterface

/* rtl/occ_result_if.sv */
// Interface: output channel carrying centroid results.
interface occ_result_if;
    import occ_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OUT_COORD_W-1:0] centroid_row;
    logic [OUT_COORD_W-1:0] centroid_col;
    logic [COUNT_W-1:0]     member_count;
    logic                   found;
    logic                   table_overflowed;
    logic                   last;

    modport source (output valid, centroid_row, centroid_col, member_count, found,
                     table_overflowed, last, input ready);
    modport sink   (input valid, centroid_row, centroid_col, member_count, found,
                    table_overflowed, last, output ready);
endinterface

/* rtl/online_centroid_clustering.sv */
// Top level of the online centroid clustering block.
// Channels: i_point takes one beat per point (command 0) or end of frame
// (command 1); o_result gives one beat per active centroid in table order at
// end of frame, last set on the final beat, or a single marker beat
// (found 0, last 1) when the frame has no active centroid. i_cfg_we with
// i_cfg_wdata sets the match radius (reset 15); write it only while idle.
// The table is a ring of MAX_CENTROIDS cells that rotates one place per step.
// Point: each entry checked takes difference, two squares and compare steps;
// then the ring rotates through each remaining position, for MAX_CENTROIDS
// rotations in all; a match adds a multiply and a serial divide. A point gives
// no result beats. End of frame: the walk steps over each stored entry, then
// the end check and flush, waiting while o_result stalls; a stalled beat
// holds in the output register and the walk waits until it is taken.
// i_point.ready is high only while idle.
// Reset (synchronous, active low) empties the table at once; no sweep.
module online_centroid_clustering (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [occ_pkg::RADIUS_W-1:0]  i_cfg_wdata,
    occ_point_if.sink                     i_point,
    occ_result_if.source                  o_result
);
    import occ_pkg::*;

    t_state                r_state, n_state;
    t_rot                  r_rot, n_rot;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [STEP_W-1:0]     r_used, n_used;
    logic                  r_ovf, n_ovf;
    logic [RADIUS_W-1:0]   r_radius;
    logic [D2_W-1:0]       r_lo, r_hi;
    logic [MEAN_W-1:0]     r_pr, r_pc, r_dr, r_dc;
    logic [D2_W-1:0]       r_sq;
    logic [NUM_W-1:0]      r_num_r, r_num_c;
    t_result               r_pend, n_pend;
    logic                  r_pend_v, n_pend_v;
    t_result               r_out, n_out;
    logic                  r_out_v, n_out_v;

    t_entry                w_entry [MAX_CENTROIDS];
    t_entry                w_next  [MAX_CENTROIDS];
    t_entry                w_head, w_new, w_upd, w_push;
    logic                  w_shift;
    logic                  w_out_free;
    logic [RAD_W-1:0]      w_rlo, w_rhi;
    logic [SQ_W-1:0]       w_sqlo, w_sqhi;
    logic [MEAN_W-1:0]     w_sq_op;
    logic [2*MEAN_W-1:0]   w_sq;
    logic [MEAN_W+COUNT_W-1:0] w_prod_r, w_prod_c;
    t_div_req              w_req_r, w_req_c;
    logic                  w_done_r, w_done_c;
    logic [MEAN_W-1:0]     w_q_r, w_q_c;
    logic [COORD_BITS-1:0] w_in_row, w_in_col;

    genvar k;
    generate
        for (k = 0; k < MAX_CENTROIDS; k++) begin : g_cell
            if (k == MAX_CENTROIDS - 1) begin : g_tail
                assign w_next[k] = w_push;
            end else begin : g_body
                assign w_next[k] = w_entry[k+1];
            end
            occ_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_next  (w_next[k]),
                .o_entry (w_entry[k])
            );
        end
    endgenerate

    assign w_head = w_entry[0];
    assign w_new  = '{mean_row: r_pr, mean_col: r_pc, count: COUNT_W'(1),
                      active: (r_rot != ROT_INSERT_SHIFT)};
    assign w_upd  = '{mean_row: w_q_r, mean_col: w_q_c,
                      count: (w_head.count < COUNT_MAX) ? w_head.count + 1'b1
                                                        : w_head.count,
                      active: w_head.active};

    assign w_in_row = COORD_BITS'(i_point.point_row);
    assign w_in_col = COORD_BITS'(i_point.point_col);

    assign w_rlo  = RAD_W'(r_radius) << FRAC_BITS;
    assign w_rhi  = (RAD_W'(r_radius) + 1'b1) << FRAC_BITS;
    assign w_sqlo = w_rlo * w_rlo;
    assign w_sqhi = w_rhi * w_rhi;

    assign w_sq_op = (r_state == ST_SQR) ? r_dr : r_dc;
    assign w_sq    = w_sq_op * w_sq_op;

    assign w_prod_r = w_head.mean_row * w_head.count;
    assign w_prod_c = w_head.mean_col * w_head.count;

    assign w_req_r = '{start: (r_state == ST_MUL), num: r_num_r,
                       den: DEN_W'(w_head.count) + 1'b1};
    assign w_req_c = '{start: (r_state == ST_MUL), num: r_num_c,
                       den: DEN_W'(w_head.count) + 1'b1};

    occ_div u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_r),
        .o_done  (w_done_r),
        .o_quot  (w_q_r)
    );

    occ_div u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_c),
        .o_done  (w_done_c),
        .o_quot  (w_q_c)
    );

    assign w_out_free = !r_out_v || o_result.ready;

    always_comb begin
        n_state  = r_state;
        n_rot    = r_rot;
        n_step   = r_step;
        n_used   = r_used;
        n_ovf    = r_ovf;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !o_result.ready;
        w_shift  = 1'b0;
        w_push   = w_head;
        unique case (r_state)
            ST_IDLE: begin
                if (i_point.valid) begin
                    n_step = '0;
                    if (i_point.command == CMD_EOF) begin
                        n_pend_v = 1'b0;
                        n_state  = ST_EMIT;
                    end else begin
                        n_rot   = ROT_KEEP;
                        n_state = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                if (r_step >= r_used) begin
                    if (r_step == STEP_W'(MAX_CENTROIDS)) begin
                        n_ovf   = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_used  = r_used + 1'b1;
                        n_rot   = ROT_INSERT;
                        n_state = ST_ROT;
                    end
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: n_state = ST_SQC;
            ST_SQC: n_state = ST_CMP;
            ST_CMP: begin
                if (r_sq < r_lo) begin
                    n_state = ST_MUL;
                end else if (r_sq < r_hi) begin
                    n_rot   = ROT_INSERT_SHIFT;
                    n_state = ST_ROT;
                end else begin
                    w_shift = 1'b1;
                    n_step  = r_step + 1'b1;
                    n_state = ST_DIFF;
                end
            end
            ST_MUL: n_state = ST_DIV;
            ST_DIV: begin
                if (w_done_r && w_done_c) begin
                    w_shift = 1'b1;
                    w_push  = w_upd;
                    n_step  = r_step + 1'b1;
                    n_rot   = ROT_KEEP;
                    n_state = (r_step == STEP_W'(MAX_CENTROIDS - 1)) ? ST_IDLE : ST_ROT;
                end
            end
            ST_ROT: begin
                w_shift = 1'b1;
                n_step  = r_step + 1'b1;
                if (r_rot != ROT_KEEP && r_step == STEP_W'(r_used - 1'b1)) begin
                    w_push = w_new;
                end else if (r_rot == ROT_INSERT_SHIFT) begin
                    w_push = w_entry[1];
                end
                if (r_step == STEP_W'(MAX_CENTROIDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (r_step >= r_used) begin
                    n_state = ST_FLUSH;
                end else if (!w_head.active) begin
                    w_shift = 1'b1;
                    n_step  = r_step + 1'b1;
                end else if (!r_pend_v || w_out_free) begin
                    if (r_pend_v) begin
                        n_out   = r_pend;
                        n_out_v = 1'b1;
                    end
                    n_pend   = '{row: OUT_COORD_W'(w_head.mean_row >> FRAC_BITS),
                                 col: OUT_COORD_W'(w_head.mean_col >> FRAC_BITS),
                                 count: w_head.count, found: 1'b1, ovf: r_ovf,
                                 last: 1'b0};
                    n_pend_v = 1'b1;
                    w_shift  = 1'b1;
                    n_step   = r_step + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = '{row: '0, col: '0, count: '0, found: 1'b0,
                                  ovf: r_ovf, last: 1'b1};
                    end
                    n_out_v  = 1'b1;
                    n_pend_v = 1'b0;
                    n_used   = '0;
                    n_ovf    = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rot    <= ROT_KEEP;
            r_step   <= '0;
            r_used   <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_radius <= RADIUS_RESET;
        end else begin
            r_state  <= n_state;
            r_rot    <= n_rot;
            r_step   <= n_step;
            r_used   <= n_used;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= D2_W'(w_sqlo);
        r_hi   <= D2_W'(w_sqhi);
        r_pend <= n_pend;
        r_out  <= n_out;
        if (r_state == ST_IDLE && i_point.valid) begin
            r_pr <= MEAN_W'(w_in_row) << FRAC_BITS;
            r_pc <= MEAN_W'(w_in_col) << FRAC_BITS;
        end
        if (r_state == ST_DIFF) begin
            r_dr <= (r_pr >= w_head.mean_row) ? r_pr - w_head.mean_row
                                              : w_head.mean_row - r_pr;
            r_dc <= (r_pc >= w_head.mean_col) ? r_pc - w_head.mean_col
                                              : w_head.mean_col - r_pc;
        end
        if (r_state == ST_SQR) begin
            r_sq <= D2_W'(w_sq);
        end else if (r_state == ST_SQC) begin
            r_sq <= r_sq + D2_W'(w_sq);
        end
        if (r_state == ST_CMP) begin
            r_num_r <= NUM_W'(w_prod_r) + NUM_W'(r_pr);
            r_num_c <= NUM_W'(w_prod_c) + NUM_W'(r_pc);
        end
    end

    assign i_point.ready           = (r_state == ST_IDLE);
    assign o_result.valid          = r_out_v;
    assign o_result.centroid_row   = r_out.row;
    assign o_result.centroid_col   = r_out.col;
    assign o_result.member_count   = r_out.count;
    assign o_result.found          = r_out.found;
    assign o_result.table_overflowed = r_out.ovf;
    assign o_result.last           = r_out.last;
endmodule

/* rtl/occ_cell.sv */
// One table cell of the centroid ring: holds an entry, loads its neighbor on shift.
module occ_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  occ_pkg::t_entry i_next,
    output occ_pkg::t_entry o_entry
);
    import occ_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
endmodule

/* rtl/occ_div.sv */
// Restoring divider, one quotient bit per cycle, for the running-mean update.
module occ_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  occ_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [occ_pkg::MEAN_W-1:0] o_quot
);
    import occ_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [MEAN_W-1:0]    r_low;
    logic [DEN_W:0]       w_trial;
    logic                 w_qbit;

    assign w_trial = {r_rem, r_low[MEAN_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(MEAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[NUM_W-1 -: DEN_W];
            r_low <= i_req.num[MEAN_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_qbit ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_low <= {r_low[MEAN_W-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;
endmodule

/* rtl/occ_checker.sv */
// Port checker for the centroid clustering block, bound to the top level.
`include "online_centroid_clustering_macros.svh"

module occ_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [occ_pkg::OUT_COORD_W-1:0] i_row,
    input logic [occ_pkg::OUT_COORD_W-1:0] i_col,
    input logic [occ_pkg::COUNT_W-1:0]   i_count,
    input logic                          i_found,
    input logic                          i_last
);
    import occ_pkg::*;

    logic [2*OUT_COORD_W+COUNT_W+1:0] w_beat;

    assign w_beat = {i_row, i_col, i_count, i_found, i_last};

    `OCC_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(w_beat))
    `OCC_ASSERT_IMP(a_marker, i_out_valid && !i_found, i_last && {i_row, i_col, i_count} == '0)
    `OCC_ASSERT_IMP(a_found_count, i_out_valid && i_found, i_count != '0)
    `OCC_ASSERT_IMP(a_frame_busy, i_out_valid && !i_last, !i_in_ready)
endmodule

bind online_centroid_clustering occ_checker u_occ_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_point.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_row       (o_result.centroid_row),
    .i_col       (o_result.centroid_col),
    .i_count     (o_result.member_count),
    .i_found     (o_result.found),
    .i_last      (o_result.last)
);

/* bench/occ_centroid_checker.sv */
// Checker: watches the point and result channels, predicts centroids, compares beats.
module occ_centroid_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [occ_pkg::RADIUS_W-1:0] i_cfg_wdata,
    occ_point_if                         i_point,
    occ_result_if                        i_result,
    output int                           o_errors,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import occ_pkg::*;

    logic [RADIUS_W-1:0] radius;
    logic [MEAN_W-1:0]   tbl_row [MAX_CENTROIDS];
    logic [MEAN_W-1:0]   tbl_col [MAX_CENTROIDS];
    logic [COUNT_W-1:0]  tbl_cnt [MAX_CENTROIDS];
    logic                tbl_act [MAX_CENTROIDS];
    int                  used;
    logic                ovf;
    t_result             centroid_q[$];
    int                  errors;

    assign o_errors  = errors;
    assign o_pending = centroid_q.size();

    function automatic logic [MEAN_W-1:0] running_mean(logic [MEAN_W-1:0] m,
                                                       logic [COUNT_W-1:0] c,
                                                       longint unsigned p);
        longint unsigned num;
        num = longint'(m) * longint'(c) + p;
        return MEAN_W'(num / (longint'(c) + 1));
    endfunction

    task automatic absorb_point(logic [IN_COORD_W-1:0] row, logic [IN_COORD_W-1:0] col);
        longint unsigned pr, pc, lo, hi, dr, dc, d2;
        logic near;
        int j;
        pr   = longint'(row) << FRAC_BITS;
        pc   = longint'(col) << FRAC_BITS;
        lo   = (longint'(radius) << FRAC_BITS) * (longint'(radius) << FRAC_BITS);
        hi   = ((longint'(radius) + 1) << FRAC_BITS) * ((longint'(radius) + 1) << FRAC_BITS);
        near = 1'b0;
        for (j = 0; j < used; j++) begin
            dr = (pr >= tbl_row[j]) ? pr - tbl_row[j] : tbl_row[j] - pr;
            dc = (pc >= tbl_col[j]) ? pc - tbl_col[j] : tbl_col[j] - pc;
            d2 = dr * dr + dc * dc;
            if (d2 < lo) begin
                tbl_row[j] = running_mean(tbl_row[j], tbl_cnt[j], pr);
                tbl_col[j] = running_mean(tbl_col[j], tbl_cnt[j], pc);
                if (tbl_cnt[j] < COUNT_MAX) tbl_cnt[j]++;
                return;
            end
            if (d2 < hi) begin
                near = 1'b1;
                break;
            end
        end
        if (near) begin
            for (int i = j; i + 1 < used; i++) begin
                tbl_row[i] = tbl_row[i+1];
                tbl_col[i] = tbl_col[i+1];
                tbl_cnt[i] = tbl_cnt[i+1];
                tbl_act[i] = tbl_act[i+1];
            end
            used--;
        end
        if (used >= MAX_CENTROIDS) begin
            ovf = 1'b1;
            return;
        end
        tbl_row[used] = MEAN_W'(pr);
        tbl_col[used] = MEAN_W'(pc);
        tbl_cnt[used] = 1;
        tbl_act[used] = !near;
        used++;
    endtask

    task automatic close_frame();
        t_result r;
        int n;
        n = 0;
        for (int j = 0; j < used; j++) begin
            if (tbl_act[j]) begin
                r.row   = OUT_COORD_W'(tbl_row[j] >> FRAC_BITS);
                r.col   = OUT_COORD_W'(tbl_col[j] >> FRAC_BITS);
                r.count = tbl_cnt[j];
                r.found = 1'b1;
                r.ovf   = ovf;
                r.last  = 1'b0;
                centroid_q.insert(centroid_q.size(), r);
                n++;
            end
        end
        if (n == 0) begin
            r = '0;
            r.ovf  = ovf;
            r.last = 1'b1;
            centroid_q.insert(centroid_q.size(), r);
        end else begin
            centroid_q[$].last = 1'b1;
        end
        used = 0;
        ovf  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            radius = RADIUS_RESET;
            used   = 0;
            ovf    = 1'b0;
            errors = 0;
            centroid_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.row   = i_result.centroid_row;
                got.col   = i_result.centroid_col;
                got.count = i_result.member_count;
                got.found = i_result.found;
                got.ovf   = i_result.table_overflowed;
                got.last  = i_result.last;
                if (centroid_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %p", got);
                end else begin
                    exp_r = centroid_q.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
                    end
                end
            end
            if (i_point.valid && i_point.ready) begin
                if (t_cmd'(i_point.command) == CMD_EOF) close_frame();
                else absorb_point(i_point.point_row, i_point.point_col);
            end
            if (i_cfg_we) radius = i_cfg_wdata;
        end
    end
endmodule

/* bench/tb_online_centroid_clustering.sv */
// Testbench top: point stimulus, result back-pressure, radius settings and verdict.
module tb_online_centroid_clustering;
    timeunit 1ns;
    timeprecision 1ps;
    import occ_pkg::*;

    localparam int SETTLE = 4 * MAX_CENTROIDS + MEAN_W + 40;
    localparam int LIMIT  = 1000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RADIUS_W-1:0] i_cfg_wdata;
    int                  errors, pending, cycles, items, stall_left;
    logic                took, no_idle, no_stall;
    logic [RADIUS_W-1:0] cur_radius;

    occ_point_if  pt_ch ();
    occ_result_if res_ch ();

    online_centroid_clustering i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_point    (pt_ch),
        .o_result   (res_ch)
    );

    occ_centroid_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_point    (pt_ch),
        .i_result   (res_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        took <= res_ch.valid && res_ch.ready;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (took) stall_left = no_stall ? 0 : $urandom_range(0, 8);
        if (stall_left > 0) begin
            res_ch.ready = 1'b0;
            stall_left--;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    task automatic send_beat(t_cmd cmd, int row, int col);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            pt_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pt_ch.valid     = 1'b1;
        pt_ch.command   = cmd;
        pt_ch.point_row = IN_COORD_W'(row);
        pt_ch.point_col = IN_COORD_W'(col);
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items++;
    endtask

    task automatic drain_and_set(logic [RADIUS_W-1:0] r);
        pt_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = r;
        cur_radius  = r;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_frame(int len, logic hold_off);
        int cr[4], cc[4], nc, k, r, c, lim;
        nc  = $urandom_range(1, 4);
        lim = (cur_radius > 40) ? 40 : cur_radius;
        for (int i = 0; i < nc; i++) begin
            cr[i] = $urandom_range(0, 1023);
            cc[i] = $urandom_range(0, 1023);
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                r = $urandom_range(0, 1023);
                c = $urandom_range(0, 1023);
            end else begin
                k = $urandom_range(0, nc - 1);
                r = cr[k] + $urandom_range(0, 2 * lim) - lim;
                c = cc[k] + $urandom_range(0, 2 * lim) - lim;
                if ($urandom_range(0, 19) == 0) begin
                    r = cr[k] + cur_radius;
                    c = cc[k];
                end
                r = (r < 0) ? 0 : (r > 1023) ? 1023 : r;
                c = (c < 0) ? 0 : (c > 1023) ? 1023 : c;
            end
            send_beat(CMD_POINT, r, c);
        end
        if (hold_off) begin
            pt_ch.valid = 1'b0;
            while (pending != 0) @(negedge i_clk);
        end
        send_beat(CMD_EOF, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    initial begin
        int sel;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        pt_ch.valid     = 1'b0;
        pt_ch.command   = CMD_POINT;
        pt_ch.point_row = '0;
        pt_ch.point_col = '0;
        items           = 0;
        no_idle         = 1'b0;
        no_stall        = 1'b0;
        cur_radius      = RADIUS_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners, a join, a near miss, then an empty frame
        send_beat(CMD_EOF, 0, 0);
        send_beat(CMD_POINT, 0, 0);
        send_beat(CMD_POINT, 1023, 1023);
        send_beat(CMD_POINT, 0, 1023);
        send_beat(CMD_POINT, 1023, 0);
        send_beat(CMD_POINT, 5, 5);
        send_beat(CMD_POINT, 3, 2);
        send_beat(CMD_POINT, 1023 - 15, 1023);
        send_beat(CMD_POINT, 1023, 1023 - 14);
        send_beat(CMD_EOF, 1023, 1023);
        send_beat(CMD_EOF, 0, 0);

        drain_and_set(8'd1);
        send_beat(CMD_POINT, 512, 512);
        send_beat(CMD_POINT, 512, 512);
        send_beat(CMD_POINT, 513, 512);
        send_beat(CMD_POINT, 700, 300);
        send_beat(CMD_EOF, 0, 0);

        drain_and_set(8'd255);
        send_beat(CMD_POINT, 0, 0);
        send_beat(CMD_POINT, 200, 100);
        send_beat(CMD_POINT, 1023, 1023);
        send_beat(CMD_POINT, 255, 0);
        send_beat(CMD_EOF, 0, 0);

        // overflow: more distinct far points than table cells
        drain_and_set(8'd15);
        no_idle = 1'b1;
        for (int i = 0; i < MAX_CENTROIDS + 6; i++)
            send_beat(CMD_POINT, (i % 10) * 100 + 20, (i / 10) * 100 + 20);
        send_beat(CMD_POINT, 20, 20);
        send_beat(CMD_EOF, 0, 0);

        while (items < 400) begin
            sel = $urandom_range(0, 5);
            drain_and_set(sel == 0 ? 8'd1 : sel == 1 ? 8'd255 :
                          RADIUS_W'($urandom_range(1, 60)));
            no_idle  = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            random_frame($urandom_range(0, 25), $urandom_range(0, 5) == 0);
        end

        pt_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && pending == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
